// ===== src/mobl_pkg.sv =====
// Package: command codes, item and result types for the multicart outer bank latch.
`default_nettype none
package mobl_pkg;

	typedef enum logic [1:0] {
		CMD_WRITE   = 2'd0,
		CMD_PRG_XLT = 2'd1,
		CMD_CHR_XLT = 2'd2,
		CMD_UNUSED  = 2'd3
	} mobl_cmd_t;

	localparam logic [3:0]  OUTER_WIN_HI  = 4'h5;
	localparam logic [5:0]  PRG_MASK_RST  = 6'h3F;
	localparam logic [7:0]  CHR_MASK_RST  = 8'hFF;
	localparam int          LOCK_BIT      = 7;
	localparam int          HIGH_BIT      = 6;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] address;
		logic [7:0]  data;
	} mobl_req_t;

	typedef struct packed {
		logic [12:0] bank;
		logic        forward_inner;
		logic        prg_refresh;
		logic        chr_refresh;
	} mobl_res_t;

	typedef struct packed {
		logic       locked;
		logic [1:0] phase;
	} mobl_status_t;

endpackage
`default_nettype wire

// ===== src/multicart_outer_bank_latch.sv =====
// Top level: request register, outer bank core and result register.
// One request is accepted per cycle while the pipeline is not stalled. The
// request register feeds the outer register update and bank composition; when
// the result stage can advance, the outer registers update and the result
// register loads at the same edge. Sustained rate is one request per clock
// while res_ready stays high. A stalled result holds the request register, and
// req_ready drops only when both stages are full. Writes in 0x5000-0x5FFF cycle
// through four outer registers until the lock bit of the fourth is set; writes
// at 0x8000 and up are flagged for the inner core.
`default_nettype none
module multicart_outer_bank_latch (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         req_valid,
	output logic        req_ready,
	input  wire  [1:0]  cmd,
	input  wire  [15:0] address,
	input  wire  [7:0]  data,
	output logic        res_valid,
	input  wire         res_ready,
	output logic [12:0] bank,
	output logic        forward_inner,
	output logic        prg_refresh,
	output logic        chr_refresh
);
	import mobl_pkg::*;

	logic         valid_s1;
	mobl_req_t    req_s1;
	logic         valid_s2;
	mobl_res_t    res_s2;
	mobl_res_t    res_c;
	mobl_status_t status;
	logic         adv_s2;
	logic         fire_s1;

	assign adv_s2    = !valid_s2 || res_ready;
	assign fire_s1   = valid_s1 && adv_s2;
	assign req_ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req_ready) valid_s1 <= req_valid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1.cmd     <= cmd;
			req_s1.address <= address;
			req_s1.data    <= data;
		end
		if (fire_s1) res_s2 <= res_c;
	end

	mobl_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire_s1),
		.req    (req_s1),
		.res    (res_c),
		.status (status)
	);

	assign res_valid     = valid_s2;
	assign bank          = res_s2.bank;
	assign forward_inner = res_s2.forward_inner;
	assign prg_refresh   = res_s2.prg_refresh;
	assign chr_refresh   = res_s2.chr_refresh;

	a_lock_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		status.locked |=> status.locked)
		else $error("outer lock bit cleared");

	a_locked_phase: assert property (@(posedge clk) disable iff (!arst_n)
		status.locked |=> $stable(status.phase))
		else $error("phase advanced while locked");

	a_fwd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && forward_inner) |-> (!prg_refresh && !chr_refresh && bank == 13'd0))
		else $error("forwarded write carries refresh or bank");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!res_valid || res_ready) |-> req_ready)
		else $error("request stalled with free result slot");

endmodule
`default_nettype wire

// ===== src/mobl_core.sv =====
// Outer register file, write decode and bank composition for one request.
`default_nettype none
module mobl_core (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    fire,
	input  mobl_pkg::mobl_req_t    req,
	output mobl_pkg::mobl_res_t    res,
	output mobl_pkg::mobl_status_t status
);
	import mobl_pkg::*;

	logic [1:0]  phase_q;
	logic [7:0]  lock_q;
	logic [8:0]  prg_base_q;
	logic [5:0]  prg_mask_q;
	logic [12:0] chr_base_q;
	logic [7:0]  chr_mask_q;

	logic        outer_wr;
	logic        hit;
	logic [3:0]  sh;

	always_comb begin
		hit      = (req.address[15:12] == OUTER_WIN_HI);
		outer_wr = (mobl_cmd_t'(req.cmd) == CMD_WRITE) && hit && !lock_q[LOCK_BIT];
		sh       = ~req.data[3:0];
		res      = '0;
		case (mobl_cmd_t'(req.cmd))
			CMD_WRITE: begin
				res.forward_inner = req.address[15];
				if (outer_wr) begin
					res.chr_refresh = (phase_q != 2'd1);
					res.prg_refresh = phase_q[0];
				end
			end
			CMD_PRG_XLT: begin
				res.bank = {4'd0, prg_base_q | {3'd0, req.data[5:0] & prg_mask_q}};
			end
			CMD_CHR_XLT: begin
				res.bank = chr_base_q | {5'd0, req.data & chr_mask_q};
			end
			default: begin
				res = '0;
			end
		endcase
		status.locked = lock_q[LOCK_BIT];
		status.phase  = phase_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= '0;
			lock_q     <= '0;
			prg_base_q <= '0;
			prg_mask_q <= PRG_MASK_RST;
			chr_base_q <= '0;
			chr_mask_q <= CHR_MASK_RST;
		end else if (fire && outer_wr) begin
			phase_q <= phase_q + 2'd1;
			case (phase_q)
				2'd0: chr_base_q[7:0] <= req.data;
				2'd1: prg_base_q[7:0] <= req.data;
				2'd2: begin
					chr_base_q[11:8] <= req.data[7:4];
					chr_mask_q       <= CHR_MASK_RST >> sh;
				end
				default: begin
					chr_base_q[12] <= req.data[HIGH_BIT];
					prg_base_q[8]  <= req.data[HIGH_BIT];
					prg_mask_q     <= ~req.data[5:0];
					lock_q         <= req.data;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== bench/multicart_outer_bank_latch_tb.sv =====
// Testbench for the multicart outer bank latch: directed and random requests checked by a scoreboard.
`timescale 1ns / 100ps
module multicart_outer_bank_latch_tb;
	import mobl_pkg::*;

	class outer_bank_scoreboard;
		logic [1:0]  phase_cnt;
		logic [7:0]  lock_mode;
		logic [8:0]  prg_base;
		logic [5:0]  prg_mask;
		logic [12:0] chr_base;
		logic [7:0]  chr_mask;
		mobl_res_t   pending[$];
		int          fails;

		function new();
			phase_cnt = '0;
			lock_mode = '0;
			prg_base  = '0;
			prg_mask  = PRG_MASK_RST;
			chr_base  = '0;
			chr_mask  = CHR_MASK_RST;
			fails     = 0;
		endfunction

		function void note_request(input logic [1:0] c, input logic [15:0] a,
				input logic [7:0] d);
			mobl_res_t r;
			r = '0;
			case (c)
				CMD_WRITE: begin
					if (a[15:12] == OUTER_WIN_HI) begin
						if (!lock_mode[LOCK_BIT]) begin
							case (phase_cnt)
								2'd0: begin
									chr_base[7:0] = d;
									r.chr_refresh = 1'b1;
								end
								2'd1: begin
									prg_base[7:0] = d;
									r.prg_refresh = 1'b1;
								end
								2'd2: begin
									chr_base[11:8] = d[7:4];
									chr_mask = 8'hFF >> (~d[3:0]);
									r.chr_refresh = 1'b1;
								end
								default: begin
									chr_base[12] = d[HIGH_BIT];
									prg_base[8] = d[HIGH_BIT];
									prg_mask = ~d[5:0];
									lock_mode = d;
									r.prg_refresh = 1'b1;
									r.chr_refresh = 1'b1;
								end
							endcase
							phase_cnt = phase_cnt + 2'd1;
						end
					end else if (a[15]) begin
						r.forward_inner = 1'b1;
					end
				end
				CMD_PRG_XLT: r.bank = {4'b0, prg_base} | {7'b0, d[5:0] & prg_mask};
				CMD_CHR_XLT: r.bank = chr_base | {5'b0, d & chr_mask};
				default: r = '0;
			endcase
			pending.push_back(r);
		endfunction

		function void check_result(input mobl_res_t got);
			mobl_res_t want;
			if (pending.size() == 0) begin
				$error("result with no request outstanding: bank %0h", got.bank);
				fails++;
				return;
			end
			want = pending.pop_front();
			if (got.bank !== want.bank) begin
				$error("bank: expected %0h, actual %0h", want.bank, got.bank);
				fails++;
			end
			if (got.forward_inner !== want.forward_inner) begin
				$error("forward_inner: expected %0b, actual %0b",
					want.forward_inner, got.forward_inner);
				fails++;
			end
			if (got.prg_refresh !== want.prg_refresh) begin
				$error("prg_refresh: expected %0b, actual %0b",
					want.prg_refresh, got.prg_refresh);
				fails++;
			end
			if (got.chr_refresh !== want.chr_refresh) begin
				$error("chr_refresh: expected %0b, actual %0b",
					want.chr_refresh, got.chr_refresh);
				fails++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	logic [1:0]  cmd = '0;
	logic [15:0] address = '0;
	logic [7:0]  data = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	logic [12:0] bank;
	logic        forward_inner;
	logic        prg_refresh;
	logic        chr_refresh;

	outer_bank_scoreboard sb;
	int burst_left = 0;
	int stall_left = 0;
	int cycle_cnt = 0;

	multicart_outer_bank_latch dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.cmd(cmd),
		.address(address),
		.data(data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.bank(bank),
		.forward_inner(forward_inner),
		.prg_refresh(prg_refresh),
		.chr_refresh(chr_refresh)
	);

	always #4 clk = ~clk;

	initial begin
		#2ms;
		$display("Simulation FAILED");
		$finish;
	end

	// receiver: free-running stretches, then random stalls
	always @(negedge clk) begin
		cycle_cnt++;
		if ((cycle_cnt % 256) < 64) begin
			res_ready <= 1'b1;
		end else if (stall_left > 0) begin
			res_ready <= 1'b0;
			stall_left--;
		end else begin
			res_ready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				stall_left = $urandom_range(1, 5);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			sb.check_result(mobl_res_t'({bank, forward_inner, prg_refresh, chr_refresh}));
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_request(input logic [1:0] c, input logic [15:0] a,
			input logic [7:0] d);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		req_valid <= 1'b1;
		cmd       <= c;
		address   <= a;
		data      <= d;
		do @(posedge clk); while (!req_ready);
		sb.note_request(c, a, d);
		burst_left--;
		@(negedge clk);
	endtask

	initial begin
		int          i;
		int          sel;
		int          waited;
		logic [1:0]  c;
		logic [15:0] a;
		logic [7:0]  d;
		bit          allow_lock;

		sb = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset view, unused command, writes outside the window
		send_request(CMD_PRG_XLT, 16'h0000, 8'hFF);
		send_request(CMD_CHR_XLT, 16'hFFFF, 8'hFF);
		send_request(CMD_CHR_XLT, 16'h1234, 8'h00);
		send_request(CMD_UNUSED,  16'hFFFF, 8'hFF);
		send_request(CMD_WRITE,   16'h0000, 8'hFF);
		send_request(CMD_WRITE,   16'h4FFF, 8'hFF);
		send_request(CMD_WRITE,   16'h6000, 8'hFF);
		send_request(CMD_WRITE,   16'h7FFF, 8'hFF);
		send_request(CMD_WRITE,   16'h8000, 8'h00);
		send_request(CMD_WRITE,   16'hFFFF, 8'hFF);
		// one full pass over the four outer registers, high bit set
		send_request(CMD_WRITE,   16'h5000, 8'hFF);
		send_request(CMD_WRITE,   16'h5FFF, 8'h00);
		send_request(CMD_WRITE,   16'h5800, 8'h5F);
		send_request(CMD_WRITE,   16'h5001, 8'h40);
		send_request(CMD_PRG_XLT, 16'h0000, 8'hFF);
		send_request(CMD_CHR_XLT, 16'h0000, 8'hFF);
		// masks at their extremes: chr mask 0, prg mask 0
		send_request(CMD_WRITE,   16'h5123, 8'h00);
		send_request(CMD_WRITE,   16'h5456, 8'hFF);
		send_request(CMD_WRITE,   16'h5789, 8'hF0);
		send_request(CMD_WRITE,   16'h5ABC, 8'h3F);
		send_request(CMD_PRG_XLT, 16'h0000, 8'hFF);
		send_request(CMD_CHR_XLT, 16'h0000, 8'hFF);
		send_request(CMD_WRITE,   16'h5DEF, 8'h12);
		send_request(CMD_WRITE,   16'h5F0F, 8'h34);
		send_request(CMD_WRITE,   16'h50F0, 8'hA8);

		for (i = 0; i < 400; i++) begin
			allow_lock = (i >= 360);
			sel = $urandom_range(0, 99);
			a = 16'($urandom);
			d = 8'($urandom);
			if (sel < 35) begin
				c = CMD_WRITE;
				a = {OUTER_WIN_HI, a[11:0]};
			end else if (sel < 45) begin
				c = CMD_WRITE;
			end else if (sel < 70) begin
				c = CMD_PRG_XLT;
			end else if (sel < 95) begin
				c = CMD_CHR_XLT;
			end else begin
				c = CMD_UNUSED;
			end
			// keep the latch open until late in the run
			if (c == CMD_WRITE && a[15:12] == OUTER_WIN_HI && sb.phase_cnt == 2'd3
					&& !allow_lock)
				d[LOCK_BIT] = 1'b0;
			send_request(c, a, d);
		end

		// make sure the lock engages, then exercise the locked latch
		while (!sb.lock_mode[LOCK_BIT]) begin
			d = 8'($urandom);
			if (sb.phase_cnt == 2'd3)
				d[LOCK_BIT] = 1'b1;
			a = 16'($urandom);
			send_request(CMD_WRITE, {OUTER_WIN_HI, a[11:0]}, d);
		end
		for (i = 0; i < 12; i++) begin
			a = 16'($urandom);
			d = 8'($urandom);
			send_request(CMD_WRITE, {OUTER_WIN_HI, a[11:0]}, d);
			send_request((i % 2) ? CMD_PRG_XLT : CMD_CHR_XLT, a, d);
		end
		req_valid <= 1'b0;

		waited = 0;
		while (sb.pending.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		if (sb.pending.size() != 0) begin
			$error("%0d results never arrived", sb.pending.size());
			sb.fails++;
		end
		repeat (10) @(posedge clk);

		if (sb.fails == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/mobl_pkg.sv
src/mobl_core.sv
src/multicart_outer_bank_latch.sv
bench/multicart_outer_bank_latch_tb.sv
